/* hdl/game_port_paddle_timer_defines.svh */
// Assertion macros shared by the checker of the paddle timer.
// Depends on nothing; included by the checker file only.
`ifndef GAME_PORT_PADDLE_TIMER_DEFINES_SVH
`define GAME_PORT_PADDLE_TIMER_DEFINES_SVH

// Whenever the antecedent holds, the consequent must hold from the same edge.
`define GPPT_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("paddle timer check failed");

// Whenever the antecedent holds, the consequent must hold at the next edge.
`define GPPT_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("paddle timer check failed");

`endif

/* hdl/gppt_pkg.sv */
// Types and constants of the game-port paddle timer.
// Depends on nothing; imported by the timer, lane and expiry modules of the block.
`default_nettype none

package gppt_pkg;

  // Request operation codes.
  typedef enum logic [1:0] {
    OP_STROBE = 2'd0,
    OP_READ   = 2'd1,
    OP_UPDATE = 2'd2
  } op_e;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_ACTION_SPEED  = 2'd0,
    REG_RELEASE_SPEED = 2'd1,
    REG_RATE_TENTHS   = 2'd2
  } reg_idx_e;

  localparam int unsigned TICK_W      = 32;
  localparam int unsigned POS_W       = 8;
  localparam int unsigned CNT_W       = 16;
  localparam int unsigned DIR_FIELDS  = 4;

  localparam logic [POS_W-1:0] POS_MAX    = 8'd255;
  localparam logic [POS_W-1:0] POS_CENTRE = 8'd127;
  localparam logic [7:0]       READ_RUNNING = 8'h80;

  // Reset values of the configuration registers (6.6 ticks held as tenths).
  localparam logic [7:0] ACTION_SPEED_RST  = 8'd8;
  localparam logic [7:0] RELEASE_SPEED_RST = 8'd8;
  localparam logic [7:0] RATE_TENTHS_RST   = 8'd66;

  typedef logic signed [1:0] dir_t;

  // Per-paddle control for one request.
  typedef struct packed {
    logic upd_en;
    logic strobe_en;
    logic pushed;
    dir_t dir;
  } lane_ctl_t;

endpackage

`default_nettype wire

/* hdl/game_port_paddle_timer.sv */
// Game-port paddle timer: NUM_PADDLES paddles with positions and one-shot timers.
// Depends on gppt_pkg, gppt_lane and gppt_expiry.
//
// Every accepted request gives exactly one result from the result register: a
// request is first captured in an input register, then its move, strobe or read
// is worked out in one pass and lands in the result register while the paddle
// state updates. One request is accepted per cycle; the block stalls only while
// a finished result waits in the result register and the input register is full.
// Reads answer 0x80 while the paddle's timer runs and 0 otherwise; strobes and
// updates answer 0. Configuration writes take effect at the edge they are given.
`default_nettype none

module game_port_paddle_timer #(
  parameter int unsigned NUM_PADDLES = 4
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // configuration
  input  wire logic                        cfg_we_i,
  input  wire logic [1:0]                  cfg_index_i,
  input  wire logic [7:0]                  cfg_wdata_i,
  // request channel
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic [1:0]                  op_i,
  input  wire logic [gppt_pkg::TICK_W-1:0] tick_now_i,
  input  wire logic [1:0]                  paddle_i,
  input  wire logic [3:0]                  active_mask_i,
  input  wire logic signed [1:0]           dir_zero_i,
  input  wire logic signed [1:0]           dir_one_i,
  input  wire logic signed [1:0]           dir_two_i,
  input  wire logic signed [1:0]           dir_three_i,
  // result channel
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic [7:0]                       read_value_o
);
  import gppt_pkg::*;

  logic [7:0]        action_speed_q;
  logic [7:0]        release_speed_q;
  logic [7:0]        rate_tenths_q;

  logic              in_valid_q;
  logic [1:0]        op_q;
  logic [TICK_W-1:0] tick_q;
  logic [1:0]        paddle_q;
  logic [3:0]        mask_q;
  dir_t              dir_q [DIR_FIELDS];

  logic [TICK_W-1:0] strobe_tick_q;
  logic              out_valid_q;
  logic [7:0]        read_value_q, read_value_d;

  logic              advance;
  logic              fire;
  logic              timer_running;
  logic              hit;
  logic [CNT_W-1:0]  sel_count;
  logic [CNT_W-1:0]  countdown [NUM_PADDLES];

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      action_speed_q  <= ACTION_SPEED_RST;
      release_speed_q <= RELEASE_SPEED_RST;
      rate_tenths_q   <= RATE_TENTHS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_ACTION_SPEED:  action_speed_q  <= cfg_wdata_i;
        REG_RELEASE_SPEED: release_speed_q <= cfg_wdata_i;
        REG_RATE_TENTHS:   rate_tenths_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Handshake: the result register frees up when empty or taken.
  assign advance    = !out_valid_q || out_ready_i;
  assign fire       = in_valid_q && advance;
  assign in_ready_o = !in_valid_q || advance;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      op_q     <= op_i;
      tick_q   <= tick_now_i;
      paddle_q <= paddle_i;
      mask_q   <= active_mask_i;
      dir_q[0] <= dir_zero_i;
      dir_q[1] <= dir_one_i;
      dir_q[2] <= dir_two_i;
      dir_q[3] <= dir_three_i;
    end
  end

  // Paddle lanes; those beyond the four input fields never move.
  for (genvar n = 0; n < NUM_PADDLES; n++) begin : g_lane
    lane_ctl_t ctl;

    if (n < DIR_FIELDS) begin : g_driven
      assign ctl.pushed = mask_q[n];
      assign ctl.dir    = dir_q[n];
    end else begin : g_idle
      assign ctl.pushed = 1'b0;
      assign ctl.dir    = '0;
    end
    assign ctl.upd_en    = fire && (op_q == OP_UPDATE);
    assign ctl.strobe_en = fire && (op_q == OP_STROBE);

    gppt_lane u_lane (
      .clk_i           (clk_i),
      .rst_ni          (rst_ni),
      .ctl_i           (ctl),
      .action_speed_i  (action_speed_q),
      .release_speed_i (release_speed_q),
      .countdown_o     (countdown[n])
    );
  end

  // Strobe time.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strobe_tick_q <= '0;
    end else if (fire && (op_q == OP_STROBE)) begin
      strobe_tick_q <= tick_q;
    end
  end

  // Select the addressed paddle's countdown; an index past the last paddle misses.
  always_comb begin
    hit       = 1'b0;
    sel_count = '0;
    for (int n = 0; n < NUM_PADDLES; n++) begin
      if (int'(paddle_q) == n) begin
        hit       = 1'b1;
        sel_count = countdown[n];
      end
    end
  end

  gppt_expiry u_expiry (
    .tick_now_i    (tick_q),
    .strobe_tick_i (strobe_tick_q),
    .countdown_i   (sel_count),
    .rate_tenths_i (rate_tenths_q),
    .running_o     (timer_running)
  );

  assign read_value_d = ((op_q == OP_READ) && hit && timer_running) ? READ_RUNNING : 8'h00;

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      read_value_q <= read_value_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign read_value_o = read_value_q;

endmodule

`default_nettype wire

/* hdl/gppt_lane.sv */
// One paddle: its position register, the move on update and the countdown load.
// Depends on gppt_pkg.
`default_nettype none

module gppt_lane (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire gppt_pkg::lane_ctl_t        ctl_i,
  input  wire logic [7:0]                 action_speed_i,
  input  wire logic [7:0]                 release_speed_i,
  output logic [gppt_pkg::CNT_W-1:0]      countdown_o
);
  import gppt_pkg::*;

  logic [POS_W-1:0]  position_q, position_d;
  logic [CNT_W-1:0]  countdown_q;
  logic [7:0]        speed;
  logic signed [10:0] delta;
  logic signed [10:0] sum_s;
  logic signed [10:0] held_s;

  // Step is the chosen speed times the signed direction.
  always_comb begin
    speed = ctl_i.pushed ? action_speed_i : release_speed_i;
    case (ctl_i.dir)
      2'b01:   delta = $signed({3'b000, speed});
      2'b11:   delta = -$signed({3'b000, speed});
      2'b10:   delta = -$signed({2'b00, speed, 1'b0});
      default: delta = '0;
    endcase
    sum_s = $signed({3'b000, position_q}) + delta;
  end

  // A released stick stops at the centre, then everything saturates to a byte.
  always_comb begin
    held_s = sum_s;
    if (!ctl_i.pushed) begin
      if ((ctl_i.dir == 2'b01) && (sum_s > 11'sd127)) begin
        held_s = $signed({3'b000, POS_CENTRE});
      end
      if (ctl_i.dir[1] && (sum_s < 11'sd127)) begin
        held_s = $signed({3'b000, POS_CENTRE});
      end
    end
    if (held_s > 11'sd255) begin
      position_d = POS_MAX;
    end else if (held_s < 11'sd0) begin
      position_d = '0;
    end else begin
      position_d = held_s[POS_W-1:0];
    end
  end

  // Position and countdown state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      position_q  <= POS_CENTRE;
      countdown_q <= '0;
    end else begin
      if (ctl_i.upd_en) begin
        position_q <= position_d;
      end
      if (ctl_i.strobe_en) begin
        countdown_q <= {8'b0, position_q} * {8'b0, position_q};
      end
    end
  end

  assign countdown_o = countdown_q;

endmodule

`default_nettype wire

/* hdl/gppt_expiry.sv */
// Expiry test of the selected one-shot: elapsed ticks times ten against rate times countdown.
// Depends on gppt_pkg.
`default_nettype none

module gppt_expiry (
  input  wire logic [gppt_pkg::TICK_W-1:0] tick_now_i,
  input  wire logic [gppt_pkg::TICK_W-1:0] strobe_tick_i,
  input  wire logic [gppt_pkg::CNT_W-1:0]  countdown_i,
  input  wire logic [7:0]                  rate_tenths_i,
  output logic                             running_o
);
  import gppt_pkg::*;

  logic [TICK_W-1:0] elapsed;
  logic [23:0]       limit;
  logic [27:0]       elapsed_x10;

  // The limit never reaches 2^24, so any elapsed count at or above that has expired.
  always_comb begin
    elapsed     = tick_now_i - strobe_tick_i;
    limit       = {16'b0, rate_tenths_i} * {8'b0, countdown_i};
    elapsed_x10 = {1'b0, elapsed[23:0], 3'b000} + {3'b000, elapsed[23:0], 1'b0};
    running_o   = (elapsed[TICK_W-1:24] == '0) && (elapsed_x10 < {4'b0000, limit});
  end

endmodule

`default_nettype wire

/* hdl/gppt_checker.sv */
// Port-level checks of the paddle timer and the bind that attaches them.
// Depends on game_port_paddle_timer_defines.svh and game_port_paddle_timer.
`default_nettype none
`include "game_port_paddle_timer_defines.svh"

module gppt_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_ready_o,
  input wire logic       out_valid_o,
  input wire logic       out_ready_i,
  input wire logic [7:0] read_value_o
);

  // A result that is not taken stays with its value.
  `GPPT_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(read_value_o))

  // An accepted request is followed by a result on show.
  `GPPT_ASSERT_IMP(a_result_due, clk_i, rst_ni, in_valid_i && in_ready_o, ##2 out_valid_o)

  // With the result register empty the block always takes a request.
  `GPPT_ASSERT_IMP(a_ready_when_empty, clk_i, rst_ni, !out_valid_o, in_ready_o)

  // A result only ever reads 0x80 (timer running) or 0.
  `GPPT_ASSERT_IMP(a_value_codes, clk_i, rst_ni, out_valid_o, (read_value_o == 8'h00) || (read_value_o == 8'h80))

endmodule

bind game_port_paddle_timer gppt_checker u_gppt_checker (.*);

`default_nettype wire
